@@ hw/rtl/tmss_pkg.sv @@
// ----------------------------------------------------------------------------
// tmss_pkg
// Shared types and constants of the three-motor start/stop sequencer.
// ----------------------------------------------------------------------------
package tmss_pkg;

  localparam int NUM_LANES = 3;
  localparam int TOTAL_W   = 14;
  localparam int DAILY_W   = 7;
  localparam int DAILY_A_W = 4;

  localparam logic [TOTAL_W-1:0] TOTAL_LIMIT    = 14'd9999;
  localparam logic [DAILY_W-1:0] DAILY_LIMIT_A  = 7'd11;
  localparam logic [DAILY_W-1:0] DAILY_LIMIT_BC = 7'd99;

  // Step codes shared by the start and the stop sequence.
  localparam logic [1:0] STEP_NONE   = 2'd0;
  localparam logic [1:0] STEP_FIRST  = 2'd1;
  localparam logic [1:0] STEP_SECOND = 2'd2;
  localparam logic [1:0] STEP_DONE   = 2'd3;

  typedef struct packed {
    logic               relay;
    logic               power_switch;
    logic               running;
    logic [TOTAL_W-1:0] total;
    logic [DAILY_W-1:0] daily;
    logic [TOTAL_W-1:0] closures;
  } lane_out_t;

endpackage

@@ hw/rtl/tmss_lane.sv @@
// ----------------------------------------------------------------------------
// tmss_lane
// One motor channel: demand debounce, closure qualification, start/stop
// sequencing and saturating counters. State advances on each loaded word.
// ----------------------------------------------------------------------------
module tmss_lane
  import tmss_pkg::*;
#(
  parameter logic [DAILY_W-1:0] DAILY_LIMIT = DAILY_LIMIT_BC
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  logic      demand_n,
  input  logic      closure_n,
  input  logic      overtime,
  output lane_out_t result
);

  logic               latched, latched_next;
  logic               low_cnt, low_cnt_next;
  logic               high_cnt, high_cnt_next;
  logic [1:0]         start_step, start_next, start_arm;
  logic [1:0]         stop_step, stop_next, stop_arm;
  logic [1:0]         cl_low, cl_low_next;
  logic [1:0]         cl_high, cl_high_next;
  logic               relay, relay_next;
  logic               power_switch, power_switch_next;
  logic               running, running_next;
  logic [TOTAL_W-1:0] total, total_next;
  logic [DAILY_W-1:0] daily, daily_next;
  logic [TOTAL_W-1:0] closures, closures_next;

  always_comb begin
    latched_next      = latched;
    low_cnt_next      = low_cnt;
    high_cnt_next     = high_cnt;
    start_arm         = start_step;
    stop_arm          = stop_step;
    cl_low_next       = cl_low;
    cl_high_next      = cl_high;
    relay_next        = relay;
    power_switch_next = power_switch;
    running_next      = running;
    total_next        = total;
    daily_next        = daily;
    closures_next     = closures;

    // Demand debounce: every second sample of a level takes effect. The
    // opposite counter is left alone on purpose.
    if (!demand_n) begin
      if (low_cnt) begin
        low_cnt_next = 1'b0;
        latched_next = 1'b1;
        stop_arm     = STEP_FIRST;
      end else begin
        low_cnt_next = 1'b1;
      end
    end else begin
      if (high_cnt) begin
        high_cnt_next = 1'b0;
        latched_next  = 1'b0;
        start_arm     = STEP_FIRST;
      end else begin
        high_cnt_next = 1'b1;
      end
    end

    // Closure qualification: a closure counts once, on the second low sample.
    if (!closure_n) begin
      if (cl_low != 2'd0) begin
        if (cl_low == 2'd1 && closures < TOTAL_LIMIT) begin
          closures_next = closures + 14'd1;
        end
        cl_low_next  = 2'd3;
        cl_high_next = 2'd0;
      end else begin
        cl_low_next = 2'd1;
      end
    end else begin
      if (cl_high != 2'd0) begin
        cl_high_next = 2'd3;
        cl_low_next  = 2'd0;
      end else begin
        cl_high_next = 2'd1;
      end
    end

    start_next = start_arm;
    stop_next  = stop_arm;
    if (!overtime && latched_next) begin
      case (start_arm)
        STEP_FIRST: begin
          relay_next = 1'b1;
          start_next = STEP_SECOND;
        end
        STEP_SECOND: begin
          power_switch_next = 1'b1;
          running_next      = 1'b1;
          start_next        = STEP_DONE;
          if (total < TOTAL_LIMIT) begin
            total_next = total + 14'd1;
          end
          if (daily < DAILY_LIMIT) begin
            daily_next = daily + 7'd1;
          end
        end
        default: begin
        end
      endcase
    end else begin
      case (stop_arm)
        STEP_FIRST: begin
          power_switch_next = 1'b0;
          stop_next         = STEP_SECOND;
        end
        STEP_SECOND: begin
          relay_next   = 1'b0;
          running_next = 1'b0;
          stop_next    = STEP_DONE;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched      <= 1'b0;
      low_cnt      <= 1'b0;
      high_cnt     <= 1'b0;
      start_step   <= STEP_FIRST;
      stop_step    <= STEP_NONE;
      cl_low       <= 2'd0;
      cl_high      <= 2'd0;
      relay        <= 1'b0;
      power_switch <= 1'b0;
      running      <= 1'b0;
      total        <= '0;
      daily        <= '0;
      closures     <= '0;
    end else if (load) begin
      latched      <= latched_next;
      low_cnt      <= low_cnt_next;
      high_cnt     <= high_cnt_next;
      start_step   <= start_next;
      stop_step    <= stop_next;
      cl_low       <= cl_low_next;
      cl_high      <= cl_high_next;
      relay        <= relay_next;
      power_switch <= power_switch_next;
      running      <= running_next;
      total        <= total_next;
      daily        <= daily_next;
      closures     <= closures_next;
    end
  end

  // The state registers double as this lane's part of the output word.
  assign result.relay        = relay;
  assign result.power_switch = power_switch;
  assign result.running      = running;
  assign result.total        = total;
  assign result.daily        = daily;
  assign result.closures     = closures;

endmodule

@@ hw/rtl/tmss_merge.sv @@
// ----------------------------------------------------------------------------
// tmss_merge
// Output stage: gathers the three lanes into one result word and tracks its
// valid flag against the downstream handshake.
// ----------------------------------------------------------------------------
module tmss_merge
  import tmss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lane_out_t            lanes [NUM_LANES],
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 slot_free,
  output logic [NUM_LANES-1:0] relay_drive,
  output logic [NUM_LANES-1:0] switch_drive,
  output logic [NUM_LANES-1:0] running_flags,
  output logic [TOTAL_W-1:0]   run_total_a,
  output logic [TOTAL_W-1:0]   run_total_b,
  output logic [TOTAL_W-1:0]   run_total_c,
  output logic [DAILY_A_W-1:0] daily_runs_a,
  output logic [DAILY_W-1:0]   daily_runs_b,
  output logic [DAILY_W-1:0]   daily_runs_c,
  output logic [TOTAL_W-1:0]   closures_a,
  output logic [TOTAL_W-1:0]   closures_b,
  output logic [TOTAL_W-1:0]   closures_c
);

  // The lane registers hold the word; a new word may load as the old one leaves.
  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      relay_drive[i]   = lanes[i].relay;
      switch_drive[i]  = lanes[i].power_switch;
      running_flags[i] = lanes[i].running;
    end
  end

  assign run_total_a  = lanes[0].total;
  assign run_total_b  = lanes[1].total;
  assign run_total_c  = lanes[2].total;
  // Channel A saturates at 11, so its count fits the narrower port.
  assign daily_runs_a = lanes[0].daily[DAILY_A_W-1:0];
  assign daily_runs_b = lanes[1].daily;
  assign daily_runs_c = lanes[2].daily;
  assign closures_a   = lanes[0].closures;
  assign closures_b   = lanes[1].closures;
  assign closures_c   = lanes[2].closures;

endmodule

@@ hw/rtl/three_motor_start_stop_sequencer_core.sv @@
// ----------------------------------------------------------------------------
// three_motor_start_stop_sequencer_core
// Three-channel motor start/stop sequencer, one control tick per word.
// ----------------------------------------------------------------------------
// The result word of a tick is registered and valid in the cycle after it is accepted.
// Throughput: one word per cycle while out_ready does not stall the output; each lane updates on every accepted word.
// A new word is taken while the previous result leaves in the same cycle.
// Reset (synchronous, active high) clears all counters and drives, arms the
// start sequence of every channel and empties the output stage.
module three_motor_start_stop_sequencer_core
  import tmss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [NUM_LANES-1:0] demand_pins,
  input  logic [NUM_LANES-1:0] closure_pins,
  input  logic [NUM_LANES-1:0] overtime_flags,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [NUM_LANES-1:0] relay_drive,
  output logic [NUM_LANES-1:0] switch_drive,
  output logic [NUM_LANES-1:0] running_flags,
  output logic [TOTAL_W-1:0]   run_total_a,
  output logic [TOTAL_W-1:0]   run_total_b,
  output logic [TOTAL_W-1:0]   run_total_c,
  output logic [DAILY_A_W-1:0] daily_runs_a,
  output logic [DAILY_W-1:0]   daily_runs_b,
  output logic [DAILY_W-1:0]   daily_runs_c,
  output logic [TOTAL_W-1:0]   closures_a,
  output logic [TOTAL_W-1:0]   closures_b,
  output logic [TOTAL_W-1:0]   closures_c
);

  logic      accept;
  lane_out_t lanes [NUM_LANES];

  assign accept = in_valid && in_ready;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    tmss_lane #(
      .DAILY_LIMIT((g == 0) ? DAILY_LIMIT_A : DAILY_LIMIT_BC)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .load     (accept),
      .demand_n (demand_pins[g]),
      .closure_n(closure_pins[g]),
      .overtime (overtime_flags[g]),
      .result   (lanes[g])
    );
  end

  tmss_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .lanes        (lanes),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .slot_free    (in_ready),
    .relay_drive  (relay_drive),
    .switch_drive (switch_drive),
    .running_flags(running_flags),
    .run_total_a  (run_total_a),
    .run_total_b  (run_total_b),
    .run_total_c  (run_total_c),
    .daily_runs_a (daily_runs_a),
    .daily_runs_b (daily_runs_b),
    .daily_runs_c (daily_runs_c),
    .closures_a   (closures_a),
    .closures_b   (closures_b),
    .closures_c   (closures_c)
  );

  // The result outputs change only when a word is taken in.
  a_hold_without_accept: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(relay_drive) && $stable(switch_drive) && $stable(run_total_a)
               && $stable(closures_b))
    else $error("lane state changed without an accepted word");

  // Every accepted word yields a result word in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted word produced no result");

  // Daily counts saturate below the totals, so a total never trails its daily count.
  a_total_covers_daily: assert property (@(posedge clk) disable iff (rst)
    ({3'd0, daily_runs_a} <= run_total_a[DAILY_W-1:0] || run_total_a >= 14'd128)
    && ({7'd0, daily_runs_b} <= run_total_b) && ({7'd0, daily_runs_c} <= run_total_c))
    else $error("daily start count exceeds total start count");

endmodule

@@ tb/sv/tb_three_motor_start_stop_sequencer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_three_motor_start_stop_sequencer_core
// Drives control ticks into the three-channel start/stop sequencer and checks
// every result word against a cycle-free model of the three lanes. It runs a
// short directed part, random ticks built mostly from held demand and closure
// levels, a periodic stretch with no stalls that starts every lane over and
// over, enough to saturate channel A's daily count, and a random tail with both
// sides stalling at random.
// ----------------------------------------------------------------------------
module tb_three_motor_start_stop_sequencer_core;
  import tmss_pkg::*;

  typedef struct packed {
    logic [NUM_LANES-1:0] demand;
    logic [NUM_LANES-1:0] closure;
    logic [NUM_LANES-1:0] overtime;
  } tick_in_t;

  typedef struct packed {
    logic [NUM_LANES-1:0] relay;
    logic [NUM_LANES-1:0] switches;
    logic [NUM_LANES-1:0] running;
    logic [TOTAL_W-1:0]   total_a;
    logic [TOTAL_W-1:0]   total_b;
    logic [TOTAL_W-1:0]   total_c;
    logic [DAILY_W-1:0]   daily_a;
    logic [DAILY_W-1:0]   daily_b;
    logic [DAILY_W-1:0]   daily_c;
    logic [TOTAL_W-1:0]   closures_a;
    logic [TOTAL_W-1:0]   closures_b;
    logic [TOTAL_W-1:0]   closures_c;
  } tick_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [NUM_LANES-1:0] demand_pins = '1;
  logic [NUM_LANES-1:0] closure_pins = '1;
  logic [NUM_LANES-1:0] overtime_flags = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [NUM_LANES-1:0] relay_drive;
  logic [NUM_LANES-1:0] switch_drive;
  logic [NUM_LANES-1:0] running_flags;
  logic [TOTAL_W-1:0]   run_total_a;
  logic [TOTAL_W-1:0]   run_total_b;
  logic [TOTAL_W-1:0]   run_total_c;
  logic [DAILY_A_W-1:0] daily_runs_a;
  logic [DAILY_W-1:0]   daily_runs_b;
  logic [DAILY_W-1:0]   daily_runs_c;
  logic [TOTAL_W-1:0]   closures_a;
  logic [TOTAL_W-1:0]   closures_b;
  logic [TOTAL_W-1:0]   closures_c;

  three_motor_start_stop_sequencer_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .demand_pins(demand_pins), .closure_pins(closure_pins),
    .overtime_flags(overtime_flags),
    .out_valid(out_valid), .out_ready(out_ready),
    .relay_drive(relay_drive), .switch_drive(switch_drive),
    .running_flags(running_flags),
    .run_total_a(run_total_a), .run_total_b(run_total_b), .run_total_c(run_total_c),
    .daily_runs_a(daily_runs_a), .daily_runs_b(daily_runs_b),
    .daily_runs_c(daily_runs_c),
    .closures_a(closures_a), .closures_b(closures_b), .closures_c(closures_c)
  );

  tick_in_t  pending_ticks[$];
  tick_out_t expected_words[$];
  int        idle_pct = 28;
  int        error_count = 0;
  int        words_checked = 0;
  int        ticks_accepted = 0;

  // Lane state of the sequencer as the checker sees it.
  logic                 demand_latched [NUM_LANES];
  logic                 demand_low_seen [NUM_LANES];
  logic                 demand_high_seen [NUM_LANES];
  logic [1:0]           start_step [NUM_LANES];
  logic [1:0]           stop_step [NUM_LANES];
  logic [1:0]           closure_low_run [NUM_LANES];
  logic [1:0]           closure_high_run [NUM_LANES];
  logic                 relay_q [NUM_LANES];
  logic                 switch_q [NUM_LANES];
  logic                 running_q [NUM_LANES];
  logic [TOTAL_W-1:0]   starts_total [NUM_LANES];
  logic [DAILY_W-1:0]   starts_today [NUM_LANES];
  logic [TOTAL_W-1:0]   closure_count [NUM_LANES];

  initial begin
    forever #2 clk = ~clk;
  end

  task clear_lanes;
    int ch;
    for (ch = 0; ch < NUM_LANES; ch++) begin
      demand_latched[ch]   = 1'b0;
      demand_low_seen[ch]  = 1'b0;
      demand_high_seen[ch] = 1'b0;
      start_step[ch]       = STEP_FIRST;
      stop_step[ch]        = STEP_NONE;
      closure_low_run[ch]  = 2'd0;
      closure_high_run[ch] = 2'd0;
      relay_q[ch]          = 1'b0;
      switch_q[ch]         = 1'b0;
      running_q[ch]        = 1'b0;
      starts_total[ch]     = '0;
      starts_today[ch]     = '0;
      closure_count[ch]    = '0;
    end
  endtask

  // Advances all three lanes by one tick and queues the word the block must return.
  task sequence_tick(input tick_in_t t);
    tick_out_t w;
    int ch;
    logic [DAILY_W-1:0] day_cap;
    for (ch = 0; ch < NUM_LANES; ch++) begin
      if (!t.demand[ch]) begin
        if (demand_low_seen[ch]) begin
          demand_low_seen[ch] = 1'b0;
          demand_latched[ch]  = 1'b1;
          stop_step[ch]       = STEP_FIRST;
        end else begin
          demand_low_seen[ch] = 1'b1;
        end
      end else begin
        if (demand_high_seen[ch]) begin
          demand_high_seen[ch] = 1'b0;
          demand_latched[ch]   = 1'b0;
          start_step[ch]       = STEP_FIRST;
        end else begin
          demand_high_seen[ch] = 1'b1;
        end
      end
      // A closure counts once, on the second low sample.
      if (!t.closure[ch]) begin
        if (closure_low_run[ch] != 2'd0) begin
          if (closure_low_run[ch] == 2'd1 && closure_count[ch] < TOTAL_LIMIT)
            closure_count[ch] = closure_count[ch] + 14'd1;
          closure_low_run[ch]  = 2'd3;
          closure_high_run[ch] = 2'd0;
        end else begin
          closure_low_run[ch] = 2'd1;
        end
      end else begin
        if (closure_high_run[ch] != 2'd0) begin
          closure_high_run[ch] = 2'd3;
          closure_low_run[ch]  = 2'd0;
        end else begin
          closure_high_run[ch] = 2'd1;
        end
      end
    end
    for (ch = 0; ch < NUM_LANES; ch++) begin
      if (!t.overtime[ch] && demand_latched[ch]) begin
        if (start_step[ch] == STEP_FIRST) begin
          relay_q[ch]    = 1'b1;
          start_step[ch] = STEP_SECOND;
        end else if (start_step[ch] == STEP_SECOND) begin
          day_cap        = (ch == 0) ? DAILY_LIMIT_A : DAILY_LIMIT_BC;
          switch_q[ch]   = 1'b1;
          running_q[ch]  = 1'b1;
          start_step[ch] = STEP_DONE;
          if (starts_total[ch] < TOTAL_LIMIT) starts_total[ch] = starts_total[ch] + 14'd1;
          if (starts_today[ch] < day_cap) starts_today[ch] = starts_today[ch] + 7'd1;
        end
      end else begin
        if (stop_step[ch] == STEP_FIRST) begin
          switch_q[ch]  = 1'b0;
          stop_step[ch] = STEP_SECOND;
        end else if (stop_step[ch] == STEP_SECOND) begin
          relay_q[ch]   = 1'b0;
          running_q[ch] = 1'b0;
          stop_step[ch] = STEP_DONE;
        end
      end
    end
    for (ch = 0; ch < NUM_LANES; ch++) begin
      w.relay[ch]    = relay_q[ch];
      w.switches[ch] = switch_q[ch];
      w.running[ch]  = running_q[ch];
    end
    w.total_a    = starts_total[0];
    w.total_b    = starts_total[1];
    w.total_c    = starts_total[2];
    w.daily_a    = starts_today[0];
    w.daily_b    = starts_today[1];
    w.daily_c    = starts_today[2];
    w.closures_a = closure_count[0];
    w.closures_b = closure_count[1];
    w.closures_c = closure_count[2];
    expected_words.push_back(w);
  endtask

  task report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                       input logic [TOTAL_W-1:0] want);
    error_count++;
    $display("%0t ns: word %0d %s got %0d expected %0d", $time, words_checked, what,
             got, want);
  endtask

  // Sender: one tick word at a time, held until the block takes it.
  always @(posedge clk) begin : drive_ticks
    tick_in_t item;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        sequence_tick({demand_pins, closure_pins, overtime_flags});
        ticks_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_ticks.size() != 0 && $urandom_range(99) >= idle_pct) begin
          item = pending_ticks.pop_front();
          in_valid       <= 1'b1;
          demand_pins    <= item.demand;
          closure_pins   <= item.closure;
          overtime_flags <= item.overtime;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word against the oldest prediction.
  always @(posedge clk) begin : check_words
    tick_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, relay_drive", TOTAL_W'(relay_drive), '0);
        end else begin
          want = expected_words.pop_front();
          if (relay_drive !== want.relay)
            report_mismatch("relay_drive", TOTAL_W'(relay_drive), TOTAL_W'(want.relay));
          if (switch_drive !== want.switches)
            report_mismatch("switch_drive", TOTAL_W'(switch_drive), TOTAL_W'(want.switches));
          if (running_flags !== want.running)
            report_mismatch("running_flags", TOTAL_W'(running_flags), TOTAL_W'(want.running));
          if (run_total_a !== want.total_a) report_mismatch("run_total_a", run_total_a, want.total_a);
          if (run_total_b !== want.total_b) report_mismatch("run_total_b", run_total_b, want.total_b);
          if (run_total_c !== want.total_c) report_mismatch("run_total_c", run_total_c, want.total_c);
          if ({3'b000, daily_runs_a} !== want.daily_a)
            report_mismatch("daily_runs_a", TOTAL_W'(daily_runs_a), TOTAL_W'(want.daily_a));
          if (daily_runs_b !== want.daily_b)
            report_mismatch("daily_runs_b", TOTAL_W'(daily_runs_b), TOTAL_W'(want.daily_b));
          if (daily_runs_c !== want.daily_c)
            report_mismatch("daily_runs_c", TOTAL_W'(daily_runs_c), TOTAL_W'(want.daily_c));
          if (closures_a !== want.closures_a)
            report_mismatch("closures_a", closures_a, want.closures_a);
          if (closures_b !== want.closures_b)
            report_mismatch("closures_b", closures_b, want.closures_b);
          if (closures_c !== want.closures_c)
            report_mismatch("closures_c", closures_c, want.closures_c);
        end
        words_checked++;
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  task add_tick(input logic [2:0] dem, input logic [2:0] clo, input logic [2:0] ovt);
    pending_ticks.push_back({dem, clo, ovt});
  endtask

  task drain_ticks;
    while (pending_ticks.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
  endtask

  // Mostly held levels with occasional flips, so that the debouncers latch often.
  task add_random_ticks(input int count);
    logic [2:0] dem_level;
    logic [2:0] clo_level;
    int n;
    int b;
    dem_level = 3'b111;
    clo_level = 3'b111;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        add_tick(3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)));
      end else begin
        for (b = 0; b < NUM_LANES; b++) begin
          if ($urandom_range(3) == 0) dem_level[b] = ~dem_level[b];
          if ($urandom_range(2) == 0) clo_level[b] = ~clo_level[b];
        end
        add_tick(dem_level, clo_level,
                 ($urandom_range(7) == 0) ? 3'($urandom_range(7)) : 3'd0);
      end
    end
  endtask

  initial begin : run_test
    int k;
    clear_lanes();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: start with overtime on an idle lane, a full start, overtime
    // stops on a running lane, demand release, glitches and closure edges.
    add_tick(3'b111, 3'b111, 3'b000);
    add_tick(3'b111, 3'b111, 3'b000);
    add_tick(3'b000, 3'b000, 3'b111);
    add_tick(3'b000, 3'b000, 3'b111);
    add_tick(3'b000, 3'b000, 3'b000);
    add_tick(3'b000, 3'b000, 3'b000);
    add_tick(3'b000, 3'b111, 3'b000);
    add_tick(3'b000, 3'b111, 3'b101);
    add_tick(3'b000, 3'b111, 3'b101);
    add_tick(3'b000, 3'b111, 3'b111);
    add_tick(3'b111, 3'b000, 3'b000);
    add_tick(3'b111, 3'b000, 3'b000);
    add_tick(3'b111, 3'b111, 3'b000);
    add_tick(3'b010, 3'b101, 3'b010);
    add_tick(3'b010, 3'b101, 3'b010);
    add_tick(3'b101, 3'b010, 3'b000);
    add_tick(3'b101, 3'b010, 3'b000);
    add_tick(3'b000, 3'b111, 3'b000);
    add_tick(3'b000, 3'b111, 3'b000);
    add_tick(3'b000, 3'b111, 3'b000);
    add_tick(3'b110, 3'b001, 3'b100);
    add_tick(3'b111, 3'b110, 3'b000);
    add_tick(3'b111, 3'b111, 3'b111);
    drain_ticks();

    add_random_ticks(200);
    drain_ticks();
    add_random_ticks(150);
    drain_ticks();

    // Periodic demand and closure pattern with no stalls: one start and one
    // closure per lane every four ticks, enough to saturate channel A's
    // daily count.
    idle_pct = 0;
    for (k = 0; k < 100; k++)
      add_tick((k % 4 < 2) ? 3'b111 : 3'b000, (k % 4 < 2) ? 3'b000 : 3'b111, 3'b000);
    drain_ticks();
    idle_pct = 28;
    add_random_ticks(30);
    drain_ticks();
    repeat (8) @(negedge clk);

    $display("Checked %0d result words from %0d ticks: directed, random and periodic runs.",
             words_checked, ticks_accepted);
    $display("Final starts %0d/%0d/%0d, closures %0d/%0d/%0d, %0d mismatches.",
             starts_total[0], starts_total[1], starts_total[2],
             closure_count[0], closure_count[1], closure_count[2], error_count);
    if (error_count == 0)
      $display("tb_three_motor_start_stop_sequencer_core: PASS");
    else
      $display("tb_three_motor_start_stop_sequencer_core: FAIL");
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Timed out with %0d words still expected.", expected_words.size());
    $display("tb_three_motor_start_stop_sequencer_core: FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/tmss_pkg.sv
hw/rtl/tmss_lane.sv
hw/rtl/tmss_merge.sv
hw/rtl/three_motor_start_stop_sequencer_core.sv
tb/sv/tb_three_motor_start_stop_sequencer_core.sv
